// ===== src/pbsw_pkg.sv =====
// ----------------------------------------------------------------------------
// pbsw_pkg
// Shared constants, codes and types for the pixel blend / stencil writer.
// ----------------------------------------------------------------------------
package pbsw_pkg;

   // Store geometry
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WDIM_W      = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W      = $clog2(MAX_HEIGHT + 1);
   localparam int CFG_DIM_W   = 9;
   localparam int DIM_CMP_A   = (CFG_DIM_W > WDIM_W) ? CFG_DIM_W : WDIM_W;
   localparam int DIM_CMP_W   = (DIM_CMP_A > HDIM_W) ? DIM_CMP_A : HDIM_W;
   localparam int PROD_W      = ROW_W + WDIM_W;

   // Pixel format
   localparam int PX_W   = 32;
   localparam int CHAN_W = 8;

   // Port widths
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = CFG_DIM_W;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 32;
   localparam int ACT_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int POS_W       = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DRAW_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_HEIGHT = 2'd3;

   // Actions
   localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLR_ALL = 2'd2;
   localparam logic [ACT_W-1:0] ACT_CLR_STN = 2'd3;

   // Draw modes
   localparam logic [1:0] DRAW_NORMAL = 2'd0;
   localparam logic [1:0] DRAW_FILL   = 2'd1;
   localparam logic [1:0] DRAW_TEST   = 2'd2;

   // Blend modes
   localparam logic [1:0] BLEND_REPLACE = 2'd0;
   localparam logic [1:0] BLEND_ALPHA   = 2'd1;
   localparam logic [1:0] BLEND_ADD     = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CLIPPED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MASKED  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_KEPT    = 2'd3;

   // Divide by 255: (x * RECIP_255) >> RECIP_SHIFT is exact for x < 2**16
   localparam int RECIP_255   = 32'h8081;
   localparam int RECIP_SHIFT = 23;
   localparam int SUM_W       = 16;

   // Blend pipeline control
   typedef struct packed {
      logic ld_sum;    // capture products and destination pixel
      logic ld_out;    // capture scaled and saturated channels
      logic additive;  // additive blend, otherwise source alpha blend
   } blend_ctl_type;

endpackage

// ===== src/pbsw_ram.sv =====
// ----------------------------------------------------------------------------
// pbsw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pbsw_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pbsw_blend.sv =====
// ----------------------------------------------------------------------------
// pbsw_blend
// Two-stage color blend: weighted sums, then divide by 255 and, when additive,
// add destination and saturate. Destination alpha passes through.
// ----------------------------------------------------------------------------
module pbsw_blend (
   input  logic                         clock,
   input  pbsw_pkg::blend_ctl_type      ctl,
   input  logic [pbsw_pkg::PX_W-1:0]    src_px,
   input  logic [pbsw_pkg::PX_W-1:0]    dst_px,
   output logic [pbsw_pkg::PX_W-1:0]    blend_px
);

   localparam int CW = pbsw_pkg::CHAN_W;
   localparam int SW = pbsw_pkg::SUM_W;

   logic [SW-1:0] sum_ff [3];
   logic [SW-1:0] sum_in [3];
   logic [CW-1:0] dchan_ff [3];
   logic [CW-1:0] dalpha_ff;
   logic [CW-1:0] dalpha_out_ff;
   logic [CW-1:0] v_ff [3];
   logic [CW-1:0] v_in [3];

   // stage 1: per-lane products
   always_comb begin
      logic [CW-1:0] a;
      logic [CW-1:0] inv_a;
      logic [SW-1:0] ps;
      logic [SW-1:0] pd;
      a     = src_px[4*CW-1 -: CW];
      inv_a = 8'd255 - a;
      for (int k = 0; k < 3; k++) begin
         ps = SW'(src_px[k*CW +: CW]) * SW'(a);
         pd = SW'(dst_px[k*CW +: CW]) * SW'(inv_a);
         sum_in[k] = ps + (ctl.additive ? '0 : pd) + SW'(127);
      end
   end

   // stage 2: reciprocal divide, additive saturation
   always_comb begin
      logic [31:0]   prod;
      logic [CW-1:0] q;
      logic [CW:0]   acc;
      for (int k = 0; k < 3; k++) begin
         prod = 32'(sum_ff[k]) * 32'(pbsw_pkg::RECIP_255);
         q    = prod[pbsw_pkg::RECIP_SHIFT +: CW];
         acc  = {1'b0, dchan_ff[k]} + {1'b0, q};
         if (ctl.additive) begin
            v_in[k] = acc[CW] ? '1 : acc[CW-1:0];
         end else begin
            v_in[k] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_sum) begin
         for (int k = 0; k < 3; k++) begin
            sum_ff[k]   <= sum_in[k];
            dchan_ff[k] <= dst_px[k*CW +: CW];
         end
         dalpha_ff <= dst_px[4*CW-1 -: CW];
      end
      if (ctl.ld_out) begin
         for (int k = 0; k < 3; k++) begin
            v_ff[k] <= v_in[k];
         end
         dalpha_out_ff <= dalpha_ff;
      end
   end

   assign blend_px = {dalpha_out_ff, v_ff[2], v_ff[1], v_ff[0]};

endmodule

// ===== src/pixel_blend_stencil_writer.sv =====
// ----------------------------------------------------------------------------
// pixel_blend_stencil_writer
// Raster output unit: RGBA8 color store and stencil store with clipping,
// stencil fill/test and replace, alpha or additive blending.
// ----------------------------------------------------------------------------
// Usage: one request is in work at a time. A write or read inside the image
// passes through address multiply, store read (registered RAM read), blend
// sums, divide by 255, write-back, then result staging. A clipped request
// goes straight to result staging. The clear actions sweep every entry of the
// cleared stores, one per cycle, then stage a result. After reset the block
// sweeps both stores to zero with req_tready low; configuration writes are
// taken meanwhile. The result sits in an output register, so a request can be
// taken while the previous result still waits for rsp_tready.
// ----------------------------------------------------------------------------
module pixel_blend_stencil_writer (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_we,
   input  logic [pbsw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pbsw_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // requests
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // x_pos[15:0], y_pos[31:16], red[39:32], green[47:40], blue[55:48],
   // alpha[63:56], draw_over[64], zero[71:65]
   input  logic [pbsw_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // action[1:0]
   input  logic [pbsw_pkg::ACT_W-1:0]            req_tuser,
   // results
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // read_red[7:0], read_green[15:8], read_blue[23:16], read_alpha[31:24]
   output logic [pbsw_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // status[1:0]
   output logic [pbsw_pkg::STATUS_W-1:0]         rsp_tuser
);

   localparam int AW = pbsw_pkg::ADDR_W;
   localparam int PW = pbsw_pkg::PX_W;
   localparam logic [AW-1:0] CLR_LAST = AW'(pbsw_pkg::STORE_DEPTH - 1);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ADDR  = 8'b0000_0010,
      ST_READ  = 8'b0000_0100,
      ST_CALC  = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_WRITE = 8'b0010_0000,
      ST_RESP  = 8'b0100_0000,
      ST_CLEAR = 8'b1000_0000
   } state_type;

   // control registers
   state_type                       state_ff, state_in;
   logic [AW-1:0]                   clr_cnt_ff, clr_cnt_in;
   logic                            clr_all_ff, clr_all_in;
   logic                            clr_boot_ff, clr_boot_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      draw_mode_ff;
   logic [1:0]                      blend_mode_ff;
   logic [pbsw_pkg::CFG_DIM_W-1:0]  img_w_ff;
   logic [pbsw_pkg::CFG_DIM_W-1:0]  img_h_ff;

   // payload registers
   logic [pbsw_pkg::ACT_W-1:0]      act_ff;
   logic [pbsw_pkg::COL_W-1:0]      x_ff;
   logic [pbsw_pkg::ROW_W-1:0]      row_ff;
   logic [PW-1:0]                   src_ff;
   logic                            over_ff;
   logic [AW-1:0]                   addr_ff, addr_in;
   logic [pbsw_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [PW-1:0]                   res_rd_ff, res_rd_in;
   logic [pbsw_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [PW-1:0]                   rsp_data_ff;

   // request fields
   logic [pbsw_pkg::POS_W-1:0]      x_u, y_u;
   logic                            accept;
   logic                            out_free;

   // clamped image size and clipping
   logic [pbsw_pkg::DIM_CMP_W-1:0]  w_ext, h_ext, w_full, h_full;
   logic [pbsw_pkg::WDIM_W-1:0]     w_cl;
   logic [pbsw_pkg::HDIM_W-1:0]     h_cl;
   logic                            in_image;
   logic [pbsw_pkg::POS_W-1:0]      row_full;

   // store ports
   logic                            col_we, stn_we, rd_en;
   logic [AW-1:0]                   wr_addr;
   logic [PW-1:0]                   col_wdata, stn_wdata;
   logic [PW-1:0]                   col_q, stn_q;
   logic [PW-1:0]                   blend_px;
   pbsw_pkg::blend_ctl_type         bctl;

   // write-back decision
   logic                            wb_col_we, wb_stn_we;
   logic [PW-1:0]                   wb_px;
   logic [pbsw_pkg::STATUS_W-1:0]   wb_status;
   logic [PW-1:0]                   wb_rd;

   assign x_u      = req_tdata[15:0];
   assign y_u      = req_tdata[31:16];
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // size clamp to the store maximum
   always_comb begin
      w_ext  = pbsw_pkg::DIM_CMP_W'(img_w_ff);
      h_ext  = pbsw_pkg::DIM_CMP_W'(img_h_ff);
      w_full = (w_ext > pbsw_pkg::DIM_CMP_W'(pbsw_pkg::MAX_WIDTH)) ?
               pbsw_pkg::DIM_CMP_W'(pbsw_pkg::MAX_WIDTH) : w_ext;
      h_full = (h_ext > pbsw_pkg::DIM_CMP_W'(pbsw_pkg::MAX_HEIGHT)) ?
               pbsw_pkg::DIM_CMP_W'(pbsw_pkg::MAX_HEIGHT) : h_ext;
      w_cl   = w_full[pbsw_pkg::WDIM_W-1:0];
      h_cl   = h_full[pbsw_pkg::HDIM_W-1:0];
   end

   // clipping and flipped row
   assign in_image = !x_u[15] && !y_u[15] &&
                     (x_u < pbsw_pkg::POS_W'(w_cl)) && (y_u < pbsw_pkg::POS_W'(h_cl));
   assign row_full = pbsw_pkg::POS_W'(h_cl) - y_u - 16'd1;

   // linear address: row * width + column
   always_comb begin
      logic [pbsw_pkg::PROD_W-1:0] prod;
      logic [pbsw_pkg::PROD_W-1:0] sum;
      prod    = pbsw_pkg::PROD_W'(row_ff) * pbsw_pkg::PROD_W'(w_cl);
      sum     = prod + pbsw_pkg::PROD_W'(x_ff);
      addr_in = sum[AW-1:0];
   end

   // write-back decision for reads and writes
   always_comb begin
      wb_col_we = 1'b0;
      wb_stn_we = 1'b0;
      wb_px     = src_ff;
      wb_status = pbsw_pkg::STATUS_DONE;
      wb_rd     = '0;
      if (act_ff == pbsw_pkg::ACT_READ) begin
         wb_rd = col_q;
      end else if (draw_mode_ff == pbsw_pkg::DRAW_FILL) begin
         if (over_ff || stn_q == '0) begin
            wb_stn_we = 1'b1;
         end else begin
            wb_status = pbsw_pkg::STATUS_KEPT;
         end
      end else if (draw_mode_ff == pbsw_pkg::DRAW_TEST && stn_q[31:24] != 8'hFF) begin
         wb_status = pbsw_pkg::STATUS_MASKED;
      end else if (!over_ff) begin
         if (col_q == '0) begin
            wb_col_we = 1'b1;
         end else begin
            wb_status = pbsw_pkg::STATUS_KEPT;
         end
      end else if (blend_mode_ff == pbsw_pkg::BLEND_ALPHA ||
                   blend_mode_ff == pbsw_pkg::BLEND_ADD) begin
         wb_col_we = 1'b1;
         wb_px     = blend_px;
      end else begin
         wb_col_we = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_all_in    = clr_all_ff;
      clr_boot_in   = clr_boot_ff;
      res_status_in = res_status_ff;
      res_rd_in     = res_rd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      req_tready    = 1'b0;
      rd_en         = 1'b0;
      col_we        = 1'b0;
      stn_we        = 1'b0;
      wr_addr       = addr_ff;
      col_wdata     = wb_px;
      stn_wdata     = wb_px;
      bctl.ld_sum   = 1'b0;
      bctl.ld_out   = 1'b0;
      bctl.additive = (blend_mode_ff == pbsw_pkg::BLEND_ADD);
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               res_status_in = pbsw_pkg::STATUS_DONE;
               res_rd_in     = '0;
               case (req_tuser) inside
                  pbsw_pkg::ACT_CLR_ALL, pbsw_pkg::ACT_CLR_STN: begin
                     clr_cnt_in  = '0;
                     clr_all_in  = (req_tuser == pbsw_pkg::ACT_CLR_ALL);
                     clr_boot_in = 1'b0;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                     if (in_image) begin
                        state_in = ST_ADDR;
                     end else begin
                        res_status_in = pbsw_pkg::STATUS_CLIPPED;
                        state_in      = ST_RESP;
                     end
                  end
               endcase
            end
         end
         ST_ADDR: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            bctl.ld_sum = 1'b1;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            bctl.ld_out = 1'b1;
            state_in    = ST_WRITE;
         end
         ST_WRITE: begin
            col_we        = wb_col_we;
            stn_we        = wb_stn_we;
            res_status_in = wb_status;
            res_rd_in     = wb_rd;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            wr_addr    = clr_cnt_ff;
            col_wdata  = '0;
            stn_wdata  = '0;
            col_we     = clr_all_ff;
            stn_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               clr_cnt_in  = '0;
               clr_boot_in = 1'b0;
               state_in    = clr_boot_ff ? ST_IDLE : ST_RESP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         clr_all_ff    <= 1'b1;
         clr_boot_ff   <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_all_ff    <= clr_all_in;
         clr_boot_ff   <= clr_boot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff  <= pbsw_pkg::DRAW_NORMAL;
         blend_mode_ff <= pbsw_pkg::BLEND_REPLACE;
         img_w_ff      <= pbsw_pkg::CFG_DIM_W'(256);
         img_h_ff      <= pbsw_pkg::CFG_DIM_W'(256);
      end else if (csr_we) begin
         unique case (csr_index)
            pbsw_pkg::CSR_DRAW_MODE:  draw_mode_ff  <= csr_wdata[1:0];
            pbsw_pkg::CSR_BLEND_MODE: blend_mode_ff <= csr_wdata[1:0];
            pbsw_pkg::CSR_IMG_WIDTH:  img_w_ff      <= csr_wdata;
            pbsw_pkg::CSR_IMG_HEIGHT: img_h_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= req_tuser;
         x_ff    <= x_u[pbsw_pkg::COL_W-1:0];
         row_ff  <= row_full[pbsw_pkg::ROW_W-1:0];
         src_ff  <= req_tdata[63:32];
         over_ff <= req_tdata[64];
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= addr_in;
      end
      res_status_ff <= res_status_in;
      res_rd_ff     <= res_rd_in;
      if (state_ff == ST_RESP && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_rd_ff;
      end
   end

   // stores
   pbsw_ram #(.ADDR_W(AW), .DATA_W(PW)) u_colour_ram (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (wr_addr),
      .wr_data (col_wdata),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (col_q)
   );

   pbsw_ram #(.ADDR_W(AW), .DATA_W(PW)) u_stencil_ram (
      .clock   (clock),
      .wr_en   (stn_we),
      .wr_addr (wr_addr),
      .wr_data (stn_wdata),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (stn_q)
   );

   // blend datapath
   pbsw_blend u_blend (
      .clock    (clock),
      .ctl      (bctl),
      .src_px   (src_ff),
      .dst_px   (col_q),
      .blend_px (blend_px)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // stores are only written at write-back or during a clear sweep
   assert property (@(posedge clock) disable iff (reset)
      (col_we || stn_we) |-> (state_ff == ST_WRITE || state_ff == ST_CLEAR))
      else $error("store written outside write-back or clear");

   // a taken request always leaves idle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request taken but sequencer stayed idle");

   // a new result only comes from the staging state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("result raised outside staging state");

   // a clear sweep starts at entry zero
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && $past(state_ff) == ST_IDLE) |-> (clr_cnt_ff == '0))
      else $error("clear sweep did not start at entry zero");

   // blend stages are loaded in order, never together
   assert property (@(posedge clock) disable iff (reset)
      bctl.ld_out |-> ($past(state_ff) == ST_CALC))
      else $error("blend output stage loaded out of order");

endmodule

// ===== tb/pixel_blend_stencil_writer_test.sv =====
// ----------------------------------------------------------------------------
// pixel_blend_stencil_writer_test
// Self-checking bench for the raster output unit. A behavioral image of the
// color and stencil stores predicts the status and read data of every
// request. Named tests cover reset contents, clipping, draw-over, blending,
// stencil fill/test and image sizes. A randomized run under three idle
// profiles on both stream sides follows.
// ----------------------------------------------------------------------------
module pixel_blend_stencil_writer_test;

   localparam int CLOCK_PERIOD   = 8;
   localparam int TIMEOUT_CYCLES = 4_000_000;
   localparam int SEGMENTS       = 8;
   localparam int SEGMENT_ITEMS  = 48;
   localparam int SETTLE_CYCLES  = 12;
   // unused mode codes, expected to fall back to normal draw / replace
   localparam logic [1:0] DRAW_SPARE  = 2'd3;
   localparam logic [1:0] BLEND_SPARE = 2'd3;

   typedef struct {
      logic [pbsw_pkg::ACT_W-1:0] action;
      logic signed [15:0]         x_pos;
      logic signed [15:0]         y_pos;
      logic [7:0]                 red;
      logic [7:0]                 green;
      logic [7:0]                 blue;
      logic [7:0]                 alpha;
      logic                       draw_over;
   } pixel_op_type;

   typedef struct {
      logic [pbsw_pkg::STATUS_W-1:0] status;
      logic [pbsw_pkg::PX_W-1:0]     pixel;
   } pixel_result_type;

   // DUT ports
   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             csr_we     = 1'b0;
   logic [pbsw_pkg::CSR_IDX_W-1:0]   csr_index  = pbsw_pkg::CSR_DRAW_MODE;
   logic [pbsw_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [pbsw_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [pbsw_pkg::ACT_W-1:0]       req_tuser  = pbsw_pkg::ACT_WRITE;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [pbsw_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [pbsw_pkg::STATUS_W-1:0]    rsp_tuser;

   // predicted block state
   logic [pbsw_pkg::PX_W-1:0] colour_image [int unsigned];
   logic [pbsw_pkg::PX_W-1:0] stencil_image [int unsigned];
   logic [1:0]                cfg_draw   = pbsw_pkg::DRAW_NORMAL;
   logic [1:0]                cfg_blend  = pbsw_pkg::BLEND_REPLACE;
   logic [8:0]                cfg_width  = 9'd256;
   logic [8:0]                cfg_height = 9'd256;

   pixel_result_type       pending_results [$];
   int                     error_count    = 0;
   int                     send_gap_pct   = 0;
   int                     recv_stall_pct = 0;
   int                     clears_left    = 4;
   string                  chan_name [4]  = '{"read_red", "read_green", "read_blue",
                                              "read_alpha"};

   pixel_blend_stencil_writer i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, wanted, $time);
      error_count++;
   endtask

   // Apply one request to the store image and return its result
   function automatic pixel_result_type apply_pixel_op(pixel_op_type op);
      pixel_result_type res;
      int               xi, yi, w, h;
      int unsigned      addr, a, s, d, v;
      logic             in_image;
      logic [31:0]      src, dst, stn, mixed;
      xi = op.x_pos;
      yi = op.y_pos;
      w  = (cfg_width > pbsw_pkg::MAX_WIDTH) ? pbsw_pkg::MAX_WIDTH : cfg_width;
      h  = (cfg_height > pbsw_pkg::MAX_HEIGHT) ? pbsw_pkg::MAX_HEIGHT : cfg_height;
      in_image = xi >= 0 && yi >= 0 && xi < w && yi < h;
      // rows count from the bottom of the image
      addr = in_image ? (h - yi - 1) * w + xi : 0;
      src  = {op.alpha, op.blue, op.green, op.red};
      dst  = colour_image.exists(addr) ? colour_image[addr] : '0;
      stn  = stencil_image.exists(addr) ? stencil_image[addr] : '0;
      res.status = pbsw_pkg::STATUS_DONE;
      res.pixel  = '0;
      case (op.action)
         pbsw_pkg::ACT_CLR_ALL: begin
            colour_image.delete();
            stencil_image.delete();
         end
         pbsw_pkg::ACT_CLR_STN: begin
            stencil_image.delete();
         end
         pbsw_pkg::ACT_READ: begin
            if (in_image) res.pixel = dst;
            else res.status = pbsw_pkg::STATUS_CLIPPED;
         end
         pbsw_pkg::ACT_WRITE: begin
            if (!in_image) begin
               res.status = pbsw_pkg::STATUS_CLIPPED;
            end else if (cfg_draw == pbsw_pkg::DRAW_FILL) begin
               if (op.draw_over || stn == '0) stencil_image[addr] = src;
               else res.status = pbsw_pkg::STATUS_KEPT;
            end else if (cfg_draw == pbsw_pkg::DRAW_TEST && stn[31:24] != 8'hff) begin
               res.status = pbsw_pkg::STATUS_MASKED;
            end else if (!op.draw_over) begin
               // only an all-zero pixel takes the source, unblended
               if (dst == '0) colour_image[addr] = src;
               else res.status = pbsw_pkg::STATUS_KEPT;
            end else if (cfg_blend == pbsw_pkg::BLEND_ALPHA ||
                         cfg_blend == pbsw_pkg::BLEND_ADD) begin
               // destination alpha is kept, rgb saturates at 255
               mixed = {dst[31:24], 24'd0};
               a = op.alpha;
               for (int k = 0; k < 3; k++) begin
                  s = src[8*k +: 8];
                  d = dst[8*k +: 8];
                  if (cfg_blend == pbsw_pkg::BLEND_ALPHA)
                     v = (s * a + d * (255 - a) + 127) / 255;
                  else v = d + (s * a + 127) / 255;
                  mixed[8*k +: 8] = (v > 255) ? 8'hff : v[7:0];
               end
               colour_image[addr] = mixed;
            end else begin
               colour_image[addr] = src;
            end
         end
      endcase
      return res;
   endfunction

   // One request transfer, with an optional idle gap in front of it
   task automatic send_pixel_op(pixel_op_type op);
      if (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(10, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op.action;
      req_tdata  <= {7'd0, op.draw_over, op.alpha, op.blue, op.green, op.red,
                     op.y_pos, op.x_pos};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_pixel_op(op));
   endtask

   // Stop sending and wait until every result is back and the block is quiet
   task automatic finish_burst();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers with the block idle
   task automatic set_config(logic [1:0] draw, logic [1:0] blend,
                             logic [8:0] width, logic [8:0] height);
      logic [pbsw_pkg::CSR_IDX_W-1:0]  idx [4];
      logic [pbsw_pkg::CSR_DATA_W-1:0] vals [4];
      idx  = '{pbsw_pkg::CSR_DRAW_MODE, pbsw_pkg::CSR_BLEND_MODE,
               pbsw_pkg::CSR_IMG_WIDTH, pbsw_pkg::CSR_IMG_HEIGHT};
      vals = '{pbsw_pkg::CSR_DATA_W'(draw), pbsw_pkg::CSR_DATA_W'(blend), width, height};
      finish_burst();
      for (int i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
      end
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_draw   = draw;
      cfg_blend  = blend;
      cfg_width  = width;
      cfg_height = height;
   endtask

   function automatic pixel_op_type make_op(logic [pbsw_pkg::ACT_W-1:0] action, int x,
                                            int y, logic [31:0] abgr, logic over);
      pixel_op_type op;
      op.action    = action;
      op.x_pos     = 16'(x);
      op.y_pos     = 16'(y);
      op.red       = abgr[7:0];
      op.green     = abgr[15:8];
      op.blue      = abgr[23:16];
      op.alpha     = abgr[31:24];
      op.draw_over = over;
      return op;
   endfunction

   // Mostly inside the image, some on the border, some anywhere
   function automatic logic signed [15:0] pick_coord(int lim);
      int          r;
      logic [31:0] raw;
      r   = $urandom_range(99, 0);
      raw = $urandom;
      if (lim > 0 && r < 72) return 16'($urandom_range(lim - 1, 0));
      else if (r < 80) return -16'sd1;
      else if (r < 88) return 16'(lim);
      return raw[15:0];
   endfunction

   function automatic logic [7:0] pick_chan();
      int r;
      r = $urandom_range(99, 0);
      if (r < 20) return 8'h00;
      else if (r < 45) return 8'hff;
      return 8'($urandom_range(255, 0));
   endfunction

   // Small sizes keep pixels colliding; zero and oversize now and then
   function automatic logic [8:0] pick_dim();
      int r;
      r = $urandom_range(99, 0);
      if (r < 5) return 9'd0;
      else if (r < 11) return 9'($urandom_range(511, 257));
      else if (r < 18) return 9'd256;
      else if (r < 28) return 9'd1;
      return 9'($urandom_range(16, 2));
   endfunction

   function automatic pixel_op_type random_pixel_op();
      pixel_op_type op;
      int           r, w, h;
      r = $urandom_range(999, 0);
      w = (cfg_width > pbsw_pkg::MAX_WIDTH) ? pbsw_pkg::MAX_WIDTH : cfg_width;
      h = (cfg_height > pbsw_pkg::MAX_HEIGHT) ? pbsw_pkg::MAX_HEIGHT : cfg_height;
      // clears sweep the whole store, so only a handful of them
      if (clears_left > 0 && r < 4) begin
         op.action = (r < 2) ? pbsw_pkg::ACT_CLR_ALL : pbsw_pkg::ACT_CLR_STN;
         clears_left--;
      end else if (r < 400) begin
         op.action = pbsw_pkg::ACT_READ;
      end else begin
         op.action = pbsw_pkg::ACT_WRITE;
      end
      op.x_pos     = pick_coord(w);
      op.y_pos     = pick_coord(h);
      op.red       = pick_chan();
      op.green     = pick_chan();
      op.blue      = pick_chan();
      op.alpha     = pick_chan();
      op.draw_over = ($urandom_range(3, 0) != 0);
      return op;
   endfunction

   // The color store reads back as zero after the reset sweep
   task automatic test_reset_state();
      set_config(pbsw_pkg::DRAW_NORMAL, pbsw_pkg::BLEND_REPLACE, 9'd256, 9'd256);
      send_pixel_op(make_op(pbsw_pkg::ACT_READ, 0, 0, 32'h0, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_READ, 255, 255, 32'h0, 1'b1));
   endtask

   // Corner writes, coordinate extremes and clipped reads
   task automatic test_replace_clip();
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 0, 0, 32'hffff_ffff, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 255, 255, 32'h7f00_8001, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, -1, 0, 32'h1234_5678, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 0, 256, 32'h1234_5678, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 32767, -32768, 32'h1234_5678, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_READ, 0, 0, 32'h0, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_READ, 255, 255, 32'h0, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_READ, -32768, 32767, 32'hffff_ffff, 1'b1));
   endtask

   // Draw over off: kept on an opaque pixel, written on a transparent one
   task automatic test_draw_over();
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 0, 0, 32'h0102_0304, 1'b0));
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 1, 0, 32'h7856_3412, 1'b0));
   endtask

   // Alpha blend, saturating additive blend, spare mode as replace
   task automatic test_blending();
      set_config(pbsw_pkg::DRAW_NORMAL, pbsw_pkg::BLEND_ALPHA, 9'd256, 9'd256);
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 1, 0, 32'h5080_00ff, 1'b1));
      set_config(pbsw_pkg::DRAW_NORMAL, pbsw_pkg::BLEND_ADD, 9'd256, 9'd256);
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 1, 0, 32'hff01_ffff, 1'b1));
      set_config(pbsw_pkg::DRAW_NORMAL, BLEND_SPARE, 9'd256, 9'd256);
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 2, 0, 32'h00aa_5533, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_READ, 1, 0, 32'h0, 1'b0));
   endtask

   // Stencil fill, kept stencil, test pass and fail, stencil clear, spare draw mode
   task automatic test_stencil();
      set_config(pbsw_pkg::DRAW_FILL, pbsw_pkg::BLEND_REPLACE, 9'd256, 9'd256);
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 3, 0, 32'hff00_0000, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 4, 0, 32'hfeff_ffff, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 3, 0, 32'h0011_2233, 1'b0));
      set_config(pbsw_pkg::DRAW_TEST, pbsw_pkg::BLEND_REPLACE, 9'd256, 9'd256);
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 3, 0, 32'h8040_2010, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 4, 0, 32'h8040_2010, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_CLR_STN, 0, 0, 32'h0, 1'b0));
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 3, 0, 32'h8040_2010, 1'b1));
      set_config(DRAW_SPARE, pbsw_pkg::BLEND_REPLACE, 9'd256, 9'd256);
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 5, 0, 32'h0908_0706, 1'b1));
   endtask

   // Zero size clips all, oversize acts as maximum, 1x1 image, full clear
   task automatic test_image_size();
      set_config(pbsw_pkg::DRAW_NORMAL, pbsw_pkg::BLEND_REPLACE, 9'd0, 9'd256);
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 0, 0, 32'h1111_1111, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_READ, 0, 0, 32'h0, 1'b1));
      set_config(pbsw_pkg::DRAW_NORMAL, pbsw_pkg::BLEND_REPLACE, 9'd511, 9'd300);
      send_pixel_op(make_op(pbsw_pkg::ACT_READ, 255, 255, 32'h0, 1'b1));
      set_config(pbsw_pkg::DRAW_NORMAL, pbsw_pkg::BLEND_REPLACE, 9'd1, 9'd1);
      send_pixel_op(make_op(pbsw_pkg::ACT_WRITE, 0, 0, 32'hc0c0_c0c0, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_READ, 1, 0, 32'h0, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_CLR_ALL, 0, 0, 32'h0, 1'b1));
      send_pixel_op(make_op(pbsw_pkg::ACT_READ, 0, 0, 32'h0, 1'b1));
   endtask

   // Random traffic; sizes held across segment pairs so that stencil
   // fills and later tests land on the same pixels
   task automatic test_random_traffic();
      int         gap_pct [3]   = '{6, 64, 0};
      int         stall_pct [3] = '{64, 6, 0};
      logic [8:0] width, height;
      width  = 9'd256;
      height = 9'd256;
      for (int p = 0; p < 3; p++) begin
         send_gap_pct   = gap_pct[p];
         recv_stall_pct = stall_pct[p];
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg % 2 == 0) begin
               width  = pick_dim();
               height = pick_dim();
            end
            set_config(2'($urandom_range(3, 0)), 2'($urandom_range(3, 0)), width, height);
            for (int n = 0; n < SEGMENT_ITEMS; n++) send_pixel_op(random_pixel_op());
         end
      end
   endtask

   // Result checker and receiver back-pressure
   always @(posedge clock) begin : rsp_check
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_tdata, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status) report_mismatch("status", rsp_tuser, want.status);
            for (int k = 0; k < 4; k++) begin
               if (rsp_tdata[8*k +: 8] !== want.pixel[8*k +: 8])
                  report_mismatch(chan_name[k], rsp_tdata[8*k +: 8], want.pixel[8*k +: 8]);
            end
         end
      end
      rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // Test sequence
   initial begin
      repeat (4) @(posedge clock);
      reset          <= 1'b0;
      send_gap_pct   = 6;
      recv_stall_pct = 64;
      test_reset_state();
      test_replace_clip();
      test_draw_over();
      test_blending();
      test_stencil();
      test_image_size();
      test_random_traffic();
      finish_burst();
      if (error_count == 0) begin
         $display("pixel_blend_stencil_writer regression: pass");
      end else begin
         $display("pixel_blend_stencil_writer regression: fail");
      end
      $finish;
   end

   // Run limit
   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("pixel_blend_stencil_writer regression: fail");
      $finish;
   end

endmodule
